// ===== src/epm_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// epm_pkg
// shared types and codes of the eased point-to-point motion core
// ----------------------------------------------------------------------------
package epm_pkg;

   // request function codes, carried on req_tuser
   localparam logic [1:0] FUNC_TICK     = 2'd0;
   localparam logic [1:0] FUNC_RETARGET = 2'd1;
   localparam logic [1:0] FUNC_PLACE    = 2'd2;

   // motion mode codes
   localparam logic [1:0] MODE_STATIC = 2'd0;
   localparam logic [1:0] MODE_LINEAR = 2'd1;
   localparam logic [1:0] MODE_SMOOTH = 2'd2;

   // configuration register indexes
   localparam logic CSR_SPEED = 1'b0;
   localparam logic CSR_MODE  = 1'b1;

   localparam int unsigned TOTAL_MAX = 131071;

   typedef enum logic [4:0] {
      DP_NONE,
      DP_LOAD,
      DP_PLACE,
      DP_TDIV_INIT,
      DP_TDIV_STEP,
      DP_SQ1,
      DP_SQ2,
      DP_MUL_X,
      DP_ADD_X,
      DP_MUL_Y,
      DP_ADD_Y,
      DP_TICK_END,
      DP_RT_BEGIN,
      DP_SQ_STEP,
      DP_SQ_NEXT,
      DP_SQRT_INIT,
      DP_SQRT_STEP,
      DP_QDIV_INIT,
      DP_QDIV_STEP,
      DP_RT_END
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic [1:0] func;
      logic       tick_active;
      logic       smooth;
      logic       same_dest;
   } dp_status_type;

   typedef struct packed {
      logic        moving;
      logic [16:0] frame_total;
      logic [17:0] frame_now;
      logic [15:0] pos_y;
      logic [15:0] pos_x;
   } rsp_data_type;

endpackage
`default_nettype wire

// ===== src/eased_point_to_point_motion_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// eased_point_to_point_motion_core
// moves a point from an origin to a destination with linear or smoothstep easing
// ----------------------------------------------------------------------------
// Requests arrive on req_*: tuser carries the function (tick, retarget,
// place), tdata the coordinates. Every request gives exactly one response on
// rsp_* with the position, frame count, frame total and moving flag after it.
// speed and motion_mode are written through csr_* while the core is idle; the
// user must see to this, the block does not enforce it. One request at a time
// is worked by a sequencer over a shared datapath:
//   place: load, place, then the response register
//   tick: serial t divider, smoothstep product in smooth mode, x and y blend
//   retarget: serial squares, square root, speed divider, one bit a cycle each
//   tick with no motion, or retarget to the same point: straight to the response
// The response sits in an output register; a new request is taken while it
// waits, and the core holds its finished result until rsp_tready frees that
// register. Reset zeroes position, frame counts, speed, mode and rsp_tvalid.
// ----------------------------------------------------------------------------
module eased_point_to_point_motion_core
   import epm_pkg::*;
#(
   parameter int COORD_BITS = 16,
   parameter int FRAC_BITS  = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,  // coord_x, coord_y
   input  wire logic [1:0]  req_tuser,  // func
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [71:0]      rsp_tdata,  // pos_x, pos_y, frame_now, frame_total, moving, zero pad
   input  wire logic        csr_wen,
   input  wire logic        csr_index,
   input  wire logic [15:0] csr_wdata
);

   dp_cmd_type    cmd;
   dp_status_type status;
   rsp_data_type  result;
   logic          emit;
   logic          rsp_free;
   logic          ready;

   logic          rsp_valid_ff, rsp_valid_in;
   rsp_data_type  rsp_data_ff, rsp_data_in;

   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = ready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, rsp_data_ff};

   epm_controller #(
      .COORD_BITS(COORD_BITS),
      .FRAC_BITS (FRAC_BITS)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_tvalid),
      .req_ready(ready),
      .rsp_free (rsp_free),
      .emit     (emit),
      .status   (status),
      .cmd      (cmd)
   );

   epm_datapath #(
      .COORD_BITS(COORD_BITS),
      .FRAC_BITS (FRAC_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .in_func   (req_tuser),
      .in_coord_x(req_tdata[15:0]),
      .in_coord_y(req_tdata[31:16]),
      .cmd       (cmd),
      .status    (status),
      .result    (result)
   );

   always_comb begin
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (emit) begin
         rsp_data_in  = result;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

endmodule
`default_nettype wire

// ===== src/epm_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// epm_datapath
// motion state, configuration, serial dividers, squarer, square root and blend unit
// ----------------------------------------------------------------------------
module epm_datapath
   import epm_pkg::*;
#(
   parameter int COORD_BITS = 16,
   parameter int FRAC_BITS  = 16
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          csr_wen,
   input  wire logic          csr_index,
   input  wire logic [15:0]   csr_wdata,
   input  wire logic [1:0]    in_func,
   input  wire logic [15:0]   in_coord_x,
   input  wire logic [15:0]   in_coord_y,
   input  wire dp_cmd_type    cmd,
   output dp_status_type      status,
   output rsp_data_type       result
);

   localparam int C    = COORD_BITS;
   localparam int F    = FRAC_BITS;
   localparam int WSQ  = 2 * C + 1;
   localparam int PW   = C + F + 3;
   localparam logic [PW-1:0]  HALF      = PW'(1) << (F - 1);
   localparam logic [F+1:0]   THREE_ONE = (F + 2)'(3) << F;
   localparam logic [WSQ-1:0] SQ_TOP    = WSQ'(1) << (2 * C);

   // architectural state
   logic [15:0]  speed_ff, speed_in;
   logic [1:0]   mode_ff, mode_in;
   logic [C-1:0] orig_x_ff, orig_x_in, orig_y_ff, orig_y_in;
   logic [C-1:0] cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   logic [C-1:0] tgt_x_ff, tgt_x_in, tgt_y_ff, tgt_y_in;
   logic [17:0]  frame_ff, frame_in;
   logic [16:0]  total_ff, total_in;

   // work registers
   logic [1:0]        func_ff, func_in;
   logic [C-1:0]      cx_ff, cx_in, cy_ff, cy_in;
   logic [17:0]       trem_ff, trem_in;
   logic [F:0]        t_ff, t_in;
   logic [F:0]        u_ff, u_in;
   logic signed [PW-1:0] prod_ff, prod_in;
   logic [C-1:0]      dy_ff, dy_in;
   logic [2*C-1:0]    mcand_ff, mcand_in;
   logic [C-1:0]      mplier_ff, mplier_in;
   logic [WSQ-1:0]    acc_ff, acc_in;
   logic [WSQ-1:0]    sv_ff, sv_in, res_ff, res_in, sbit_ff, sbit_in;
   logic [C:0]        qd_ff, qd_in, q_ff, q_in;
   logic [16:0]       qrem_ff, qrem_in;

   logic [17:0]          r2_t;
   logic [2*F+1:0]       sq_prod;
   logic [2*F+2:0]       sm_prod;
   logic [F+1:0]         factor;
   logic signed [C:0]    diff;
   logic signed [F+1:0]  t_s;
   logic [PW-1:0]        blend_sum;
   logic [C-1:0]         blend_orig;
   logic [WSQ:0]         s_try;
   logic [16:0]          q_r2;
   logic [C-1:0]         adx, ady;

   assign status.func        = func_ff;
   assign status.tick_active = (mode_ff != MODE_STATIC) && (total_ff != 17'd0)
                               && (frame_ff <= {1'b0, total_ff});
   assign status.smooth      = (mode_ff == MODE_SMOOTH);
   assign status.same_dest   = (cx_ff == tgt_x_ff) && (cy_ff == tgt_y_ff);

   assign result.pos_x       = 16'(cur_x_ff);
   assign result.pos_y       = 16'(cur_y_ff);
   assign result.frame_now   = frame_ff;
   assign result.frame_total = total_ff;
   assign result.moving      = status.tick_active;

   always_comb begin
      r2_t       = {trem_ff[16:0], 1'b0};
      sq_prod    = t_ff * t_ff;
      factor     = THREE_ONE - {t_ff, 1'b0};
      sm_prod    = u_ff * factor;
      t_s        = $signed({1'b0, t_ff});
      blend_orig = (cmd.op == DP_ADD_Y || cmd.op == DP_MUL_Y) ? orig_y_ff : orig_x_ff;
      if (cmd.op == DP_MUL_Y) begin
         diff = $signed({1'b0, tgt_y_ff}) - $signed({1'b0, orig_y_ff});
      end else begin
         diff = $signed({1'b0, tgt_x_ff}) - $signed({1'b0, orig_x_ff});
      end
      blend_sum = {3'b000, blend_orig, {F{1'b0}}} + PW'(prod_ff) + HALF;
      s_try     = {1'b0, res_ff} + {1'b0, sbit_ff};
      q_r2      = {qrem_ff[15:0], qd_ff[C]};
      adx       = (cur_x_ff >= cx_ff) ? cur_x_ff - cx_ff : cx_ff - cur_x_ff;
      ady       = (cur_y_ff >= cy_ff) ? cur_y_ff - cy_ff : cy_ff - cur_y_ff;
   end

   always_comb begin
      speed_in  = speed_ff;
      mode_in   = mode_ff;
      orig_x_in = orig_x_ff;
      orig_y_in = orig_y_ff;
      cur_x_in  = cur_x_ff;
      cur_y_in  = cur_y_ff;
      tgt_x_in  = tgt_x_ff;
      tgt_y_in  = tgt_y_ff;
      frame_in  = frame_ff;
      total_in  = total_ff;
      func_in   = func_ff;
      cx_in     = cx_ff;
      cy_in     = cy_ff;
      trem_in   = trem_ff;
      t_in      = t_ff;
      u_in      = u_ff;
      prod_in   = prod_ff;
      dy_in     = dy_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      acc_in    = acc_ff;
      sv_in     = sv_ff;
      res_in    = res_ff;
      sbit_in   = sbit_ff;
      qd_in     = qd_ff;
      q_in      = q_ff;
      qrem_in   = qrem_ff;

      if (csr_wen) begin
         case (csr_index)
            CSR_SPEED: speed_in = csr_wdata;
            CSR_MODE:  mode_in  = csr_wdata[1:0];
            default:   ;
         endcase
      end

      case (cmd.op)
         DP_LOAD: begin
            func_in = in_func;
            cx_in   = C'(in_coord_x);
            cy_in   = C'(in_coord_y);
         end
         DP_PLACE: begin
            orig_x_in = cx_ff;
            cur_x_in  = cx_ff;
            tgt_x_in  = cx_ff;
            orig_y_in = cy_ff;
            cur_y_in  = cy_ff;
            tgt_y_in  = cy_ff;
            frame_in  = 18'd0;
            total_in  = 17'd0;
         end
         DP_TDIV_INIT: begin
            // frame never exceeds total here, so the integer bit is 0 or 1
            if (frame_ff >= {1'b0, total_ff}) begin
               trem_in = frame_ff - {1'b0, total_ff};
               t_in    = (F + 1)'(1);
            end else begin
               trem_in = frame_ff;
               t_in    = '0;
            end
         end
         DP_TDIV_STEP: begin
            if (r2_t >= {1'b0, total_ff}) begin
               trem_in = r2_t - {1'b0, total_ff};
               t_in    = {t_ff[F-1:0], 1'b1};
            end else begin
               trem_in = r2_t;
               t_in    = {t_ff[F-1:0], 1'b0};
            end
         end
         DP_SQ1: u_in = sq_prod[F +: F+1];
         DP_SQ2: t_in = sm_prod[F +: F+1];
         DP_MUL_X, DP_MUL_Y: prod_in = PW'(diff * t_s);
         DP_ADD_X: cur_x_in = blend_sum[F +: C];
         DP_ADD_Y: cur_y_in = blend_sum[F +: C];
         DP_TICK_END: frame_in = frame_ff + 18'd1;
         DP_RT_BEGIN: begin
            orig_x_in = cur_x_ff;
            orig_y_in = cur_y_ff;
            tgt_x_in  = cx_ff;
            tgt_y_in  = cy_ff;
            dy_in     = ady;
            mcand_in  = (2 * C)'(adx);
            mplier_in = adx;
            acc_in    = '0;
         end
         DP_SQ_STEP: begin
            if (mplier_ff[0]) begin
               acc_in = acc_ff + WSQ'(mcand_ff);
            end
            mcand_in  = {mcand_ff[2*C-2:0], 1'b0};
            mplier_in = mplier_ff >> 1;
         end
         DP_SQ_NEXT: begin
            mcand_in  = (2 * C)'(dy_ff);
            mplier_in = dy_ff;
         end
         DP_SQRT_INIT: begin
            sv_in   = acc_ff;
            res_in  = '0;
            sbit_in = SQ_TOP;
         end
         DP_SQRT_STEP: begin
            if ({1'b0, sv_ff} >= s_try) begin
               sv_in  = sv_ff - WSQ'(s_try);
               res_in = (res_ff >> 1) + sbit_ff;
            end else begin
               res_in = res_ff >> 1;
            end
            sbit_in = sbit_ff >> 2;
         end
         DP_QDIV_INIT: begin
            qd_in   = res_ff[C:0];
            q_in    = '0;
            qrem_in = '0;
         end
         DP_QDIV_STEP: begin
            if (q_r2 >= {1'b0, speed_ff}) begin
               qrem_in = q_r2 - {1'b0, speed_ff};
               q_in    = {q_ff[C-1:0], 1'b1};
            end else begin
               qrem_in = q_r2;
               q_in    = {q_ff[C-1:0], 1'b0};
            end
            qd_in = {qd_ff[C-1:0], 1'b0};
         end
         DP_RT_END: begin
            if (speed_ff == 16'd0) begin
               total_in = 17'd0;
            end else if (32'(q_ff) > TOTAL_MAX) begin
               total_in = 17'(TOTAL_MAX);
            end else begin
               total_in = 17'(q_ff);
            end
            frame_in = 18'd0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         speed_ff  <= '0;
         mode_ff   <= '0;
         orig_x_ff <= '0;
         orig_y_ff <= '0;
         cur_x_ff  <= '0;
         cur_y_ff  <= '0;
         tgt_x_ff  <= '0;
         tgt_y_ff  <= '0;
         frame_ff  <= '0;
         total_ff  <= '0;
      end else begin
         speed_ff  <= speed_in;
         mode_ff   <= mode_in;
         orig_x_ff <= orig_x_in;
         orig_y_ff <= orig_y_in;
         cur_x_ff  <= cur_x_in;
         cur_y_ff  <= cur_y_in;
         tgt_x_ff  <= tgt_x_in;
         tgt_y_ff  <= tgt_y_in;
         frame_ff  <= frame_in;
         total_ff  <= total_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff   <= func_in;
      cx_ff     <= cx_in;
      cy_ff     <= cy_in;
      trem_ff   <= trem_in;
      t_ff      <= t_in;
      u_ff      <= u_in;
      prod_ff   <= prod_in;
      dy_ff     <= dy_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      acc_ff    <= acc_in;
      sv_ff     <= sv_in;
      res_ff    <= res_in;
      sbit_ff   <= sbit_in;
      qd_ff     <= qd_in;
      q_ff      <= q_in;
      qrem_ff   <= qrem_in;
   end

endmodule
`default_nettype wire

// ===== src/epm_controller.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// epm_controller
// sequencer that steps the datapath through tick, retarget and place
// ----------------------------------------------------------------------------
module epm_controller
   import epm_pkg::*;
#(
   parameter int COORD_BITS = 16,
   parameter int FRAC_BITS  = 16
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   input  wire logic          rsp_free,
   output logic               emit,
   input  wire dp_status_type status,
   output dp_cmd_type         cmd
);

   localparam int MAXN  = (COORD_BITS + 1 > FRAC_BITS) ? COORD_BITS + 1 : FRAC_BITS;
   localparam int CNT_W = $clog2(MAXN + 1);
   localparam logic [CNT_W-1:0] LAST_F  = CNT_W'(FRAC_BITS - 1);
   localparam logic [CNT_W-1:0] LAST_C  = CNT_W'(COORD_BITS - 1);
   localparam logic [CNT_W-1:0] LAST_C1 = CNT_W'(COORD_BITS);

   typedef enum logic [18:0] {
      ST_IDLE   = 19'b0000000000000000001,
      ST_DECODE = 19'b0000000000000000010,
      ST_TDIV   = 19'b0000000000000000100,
      ST_SQ1    = 19'b0000000000000001000,
      ST_SQ2    = 19'b0000000000000010000,
      ST_MULX   = 19'b0000000000000100000,
      ST_ADDX   = 19'b0000000000001000000,
      ST_MULY   = 19'b0000000000010000000,
      ST_ADDY   = 19'b0000000000100000000,
      ST_TEND   = 19'b0000000001000000000,
      ST_SQX    = 19'b0000000010000000000,
      ST_SQN    = 19'b0000000100000000000,
      ST_SQY    = 19'b0000001000000000000,
      ST_SQI    = 19'b0000010000000000000,
      ST_SQRT   = 19'b0000100000000000000,
      ST_QDI    = 19'b0001000000000000000,
      ST_QDIV   = 19'b0010000000000000000,
      ST_REND   = 19'b0100000000000000000,
      ST_DONE   = 19'b1000000000000000000
   } state_type;

   state_type       state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd.op   = DP_NONE;
      emit     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.op   = DP_LOAD;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            cnt_in   = '0;
            state_in = ST_DONE;
            case (status.func)
               FUNC_TICK: begin
                  if (status.tick_active) begin
                     cmd.op   = DP_TDIV_INIT;
                     state_in = ST_TDIV;
                  end
               end
               FUNC_RETARGET: begin
                  if (!status.same_dest) begin
                     cmd.op   = DP_RT_BEGIN;
                     state_in = ST_SQX;
                  end
               end
               FUNC_PLACE: cmd.op = DP_PLACE;
               default: ;
            endcase
         end
         ST_TDIV: begin
            cmd.op = DP_TDIV_STEP;
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == LAST_F) begin
               cnt_in   = '0;
               state_in = status.smooth ? ST_SQ1 : ST_MULX;
            end
         end
         ST_SQ1: begin
            cmd.op   = DP_SQ1;
            state_in = ST_SQ2;
         end
         ST_SQ2: begin
            cmd.op   = DP_SQ2;
            state_in = ST_MULX;
         end
         ST_MULX: begin
            cmd.op   = DP_MUL_X;
            state_in = ST_ADDX;
         end
         ST_ADDX: begin
            cmd.op   = DP_ADD_X;
            state_in = ST_MULY;
         end
         ST_MULY: begin
            cmd.op   = DP_MUL_Y;
            state_in = ST_ADDY;
         end
         ST_ADDY: begin
            cmd.op   = DP_ADD_Y;
            state_in = ST_TEND;
         end
         ST_TEND: begin
            cmd.op   = DP_TICK_END;
            state_in = ST_DONE;
         end
         ST_SQX: begin
            cmd.op = DP_SQ_STEP;
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == LAST_C) begin
               cnt_in   = '0;
               state_in = ST_SQN;
            end
         end
         ST_SQN: begin
            cmd.op   = DP_SQ_NEXT;
            state_in = ST_SQY;
         end
         ST_SQY: begin
            cmd.op = DP_SQ_STEP;
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == LAST_C) begin
               cnt_in   = '0;
               state_in = ST_SQI;
            end
         end
         ST_SQI: begin
            cmd.op   = DP_SQRT_INIT;
            state_in = ST_SQRT;
         end
         ST_SQRT: begin
            cmd.op = DP_SQRT_STEP;
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == LAST_C1) begin
               cnt_in   = '0;
               state_in = ST_QDI;
            end
         end
         ST_QDI: begin
            cmd.op   = DP_QDIV_INIT;
            state_in = ST_QDIV;
         end
         ST_QDIV: begin
            cmd.op = DP_QDIV_STEP;
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == LAST_C1) begin
               cnt_in   = '0;
               state_in = ST_REND;
            end
         end
         ST_REND: begin
            cmd.op   = DP_RT_END;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // wait for the response register to drain
            if (rsp_free) begin
               emit     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule
`default_nettype wire
